[src/volume_section_stream_checker_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the section stream checker
// Shared concurrent assertion forms, sampled on clock and gated by reset.
// ----------------------------------------------------------------------------
`ifndef VOLUME_SECTION_STREAM_CHECKER_ASSERT_SVH
`define VOLUME_SECTION_STREAM_CHECKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VSSC_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VSSC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after reset is seen.
`define VSSC_ASSERT_RESET(label, cons, msg) \
   label: assert property (@(posedge clock) reset |=> (cons)) \
      else $error(msg);

`endif

[src/vssc_pkg.sv]
// ----------------------------------------------------------------------------
// Section stream checker package
// Status codes, header layout constants, the snapshot handed to the judge,
// and the byte-wide reflected CRC-32 step.
// ----------------------------------------------------------------------------
package vssc_pkg;

   localparam logic [31:0] CRC_POLY       = 32'hEDB88320;
   localparam logic [31:0] HDR_CRC_LEN    = 32'd44;
   localparam logic [31:0] HDR_FIXED_LEN  = 32'd48;
   localparam logic [3:0]  SLOT_RESERVED0 = 4'd9;    // byte offset 36
   localparam logic [3:0]  SLOT_RESERVED1 = 4'd10;   // byte offset 40
   localparam logic [3:0]  SLOT_HDR_CRC   = 4'd11;   // byte offset 44
   localparam int          HDR_WORDS      = 9;
   localparam logic [15:0] WORD_BYTES     = 16'd2;

   localparam logic        CSR_MAGIC   = 1'b0;
   localparam logic        CSR_VERSION = 1'b1;

   typedef enum logic [2:0] {
      STATUS_OK,
      STATUS_HEADER_BAD,
      STATUS_SIZE_MISMATCH,
      STATUS_PAYLOAD_CRC_BAD,
      STATUS_SPAN_BAD,
      STATUS_WORDS_UNCOVERED
   } status_type;

   // Everything the verdict needs, taken on the final byte of a file.
   typedef struct packed {
      logic [31:0]                 size;
      logic [HDR_WORDS-1:0][31:0]  fields;
      logic                        hdr_bad;
      logic                        span_bad;
      logic [31:0]                 payload_crc;
      logic [31:0]                 words_covered;
   } snap_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
      end
      return c;
   endfunction

endpackage

[src/vssc_scan.sv]
// ----------------------------------------------------------------------------
// Section stream byte scanner
// Runs both CRCs, captures the header words, checks reserved words, the
// header CRC and the record spans, one byte per cycle while take is high.
// ----------------------------------------------------------------------------
`include "volume_section_stream_checker_assert.svh"

module vssc_scan import vssc_pkg::*; #(
   parameter int HEADER_SIZE = 48,
   parameter int RECORD_SIZE = 8
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     take,
   input  logic [7:0] byte_in,
   input  logic     last_in,
   output snap_type snap
);

   localparam int                WITHIN_W  = $clog2(RECORD_SIZE);
   localparam logic [31:0]       POS_MAX   = '1;
   localparam logic [31:0]       HDR_START = 32'(HEADER_SIZE);
   localparam logic [WITHIN_W-1:0] REC_LAST = WITHIN_W'(RECORD_SIZE - 1);
   // The span sits in the first eight bytes of a record.
   localparam logic [WITHIN_W-1:0] SPAN_TAP = WITHIN_W'(7);

   logic [31:0]                pos_ff, pos_in;
   logic [31:0]                hcrc_ff, hcrc_in;
   logic [31:0]                pcrc_ff, pcrc_in;
   logic [HDR_WORDS-1:0][31:0] fields_ff, fields_in;
   logic [63:0]                span_ff, span_in;
   logic [31:0]                nwe_ff, nwe_in;
   logic                       hdr_bad_ff, hdr_bad_in;
   logic                       span_bad_ff, span_bad_in;
   logic [WITHIN_W-1:0]        within_ff, within_in;
   logic [31:0]                rec_idx_ff, rec_idx_in;

   logic [31:0] word;
   logic [3:0]  slot;

   assign word = span_in[63:32];
   assign slot = pos_ff[5:2];

   always_comb begin
      pos_in      = pos_ff;
      hcrc_in     = hcrc_ff;
      pcrc_in     = pcrc_ff;
      fields_in   = fields_ff;
      span_in     = span_ff;
      nwe_in      = nwe_ff;
      hdr_bad_in  = hdr_bad_ff;
      span_bad_in = span_bad_ff;
      within_in   = within_ff;
      rec_idx_in  = rec_idx_ff;
      if (pos_ff != POS_MAX) begin
         span_in = {byte_in, span_ff[63:8]};
         if (pos_ff < HDR_CRC_LEN) begin
            hcrc_in = crc_byte(hcrc_ff, byte_in);
         end
         if (pos_ff < HDR_FIXED_LEN && pos_ff[1:0] == 2'b11) begin
            if (slot < 4'(HDR_WORDS)) begin
               fields_in[slot] = word;
            end else if (slot == SLOT_RESERVED0 || slot == SLOT_RESERVED1) begin
               if (word != '0) hdr_bad_in = 1'b1;
            end else if (slot == SLOT_HDR_CRC) begin
               // The header CRC run is complete once byte 44 is reached.
               if (word != ~hcrc_ff) hdr_bad_in = 1'b1;
            end
         end
         if (pos_ff >= HDR_START) begin
            pcrc_in = crc_byte(pcrc_ff, byte_in);
            if (within_ff == REC_LAST) begin
               within_in  = '0;
               rec_idx_in = rec_idx_ff + 32'd1;
            end else begin
               within_in = within_ff + WITHIN_W'(1);
            end
            if (rec_idx_ff < fields_ff[3] && within_ff == SPAN_TAP && !span_bad_ff) begin
               if (word == '0 || span_in[31:0] != nwe_ff ||
                   word > fields_ff[4] - nwe_ff) begin
                  span_bad_in = 1'b1;
               end else begin
                  nwe_in = nwe_ff + word;
               end
            end
         end
         pos_in = pos_ff + 32'd1;
      end
   end

   assign snap.size          = pos_in;
   assign snap.fields        = fields_in;
   assign snap.hdr_bad       = hdr_bad_in;
   assign snap.span_bad      = span_bad_in;
   assign snap.payload_crc   = pcrc_in;
   assign snap.words_covered = nwe_in;

   // The byte that ends a file also returns the scanner to its start state.
   always_ff @(posedge clock) begin
      if (reset || (take && last_in)) begin
         pos_ff      <= '0;
         hcrc_ff     <= '1;
         pcrc_ff     <= '1;
         fields_ff   <= '0;
         span_ff     <= '0;
         nwe_ff      <= '0;
         hdr_bad_ff  <= 1'b0;
         span_bad_ff <= 1'b0;
         within_ff   <= '0;
         rec_idx_ff  <= '0;
      end else if (take) begin
         pos_ff      <= pos_in;
         hcrc_ff     <= hcrc_in;
         pcrc_ff     <= pcrc_in;
         fields_ff   <= fields_in;
         span_ff     <= span_in;
         nwe_ff      <= nwe_in;
         hdr_bad_ff  <= hdr_bad_in;
         span_bad_ff <= span_bad_in;
         within_ff   <= within_in;
         rec_idx_ff  <= rec_idx_in;
      end
   end

   `VSSC_ASSERT_NEXT(a_final_restarts, take && last_in, pos_ff == '0 && nwe_ff == '0, "scanner did not restart after the final byte")
   `VSSC_ASSERT_IMPLY(a_words_bounded, 1'b1, nwe_ff <= fields_ff[4], "span coverage ran past the word count")
   `VSSC_ASSERT_NEXT(a_idle_holds, !take, pos_ff == $past(pos_ff), "byte position moved without a transfer")

endmodule

[src/vssc_judge.sv]
// ----------------------------------------------------------------------------
// Section stream verdict
// Turns the end-of-file snapshot into a status, first failing check wins.
// ----------------------------------------------------------------------------
module vssc_judge import vssc_pkg::*; #(
   parameter int HEADER_SIZE = 48,
   parameter int RECORD_SIZE = 8
) (
   input  snap_type    snap,
   input  logic [31:0] expected_magic,
   input  logic [15:0] expected_version,
   output status_type  status
);

   localparam logic [31:0] REC_BYTES  = 32'(RECORD_SIZE);
   localparam logic [31:0] RC_LIMIT   = 32'(64'hFFFF_FFFF / RECORD_SIZE);
   localparam logic [31:0] WC_LIMIT   = 32'h7FFF_FFFF;
   localparam logic [15:0] HDR_SIZE16 = 16'(HEADER_SIZE);
   localparam logic [15:0] REC_SIZE16 = 16'(RECORD_SIZE);

   logic [31:0] fb, rc, wc, rb, sb;
   logic [31:0] rb_expect;
   logic [33:0] sum_bytes, body_bytes;
   logic        header_bad, size_bad;

   assign fb = snap.fields[2];
   assign rc = snap.fields[3];
   assign wc = snap.fields[4];
   assign rb = snap.fields[6];
   assign sb = snap.fields[7];

   assign rb_expect  = rc * REC_BYTES;
   assign sum_bytes  = {2'b00, rb} + {2'b00, sb};
   // A file shorter than the header wraps to a value no sum can reach.
   assign body_bytes = {2'b00, fb} - 34'(HEADER_SIZE);

   assign header_bad = snap.size < 32'(HEADER_SIZE) || snap.hdr_bad ||
                       snap.fields[0] != expected_magic ||
                       snap.fields[1][15:0] != expected_version ||
                       snap.fields[1][31:16] != HDR_SIZE16 ||
                       snap.fields[5][15:0] != REC_SIZE16 ||
                       snap.fields[5][31:16] != WORD_BYTES;

   assign size_bad = fb != snap.size || rc == '0 || wc == '0 ||
                     rc > RC_LIMIT || wc > WC_LIMIT ||
                     rb != rb_expect || sb != {wc[30:0], 1'b0} ||
                     sum_bytes != body_bytes;

   always_comb begin
      if (header_bad)                              status = STATUS_HEADER_BAD;
      else if (size_bad)                           status = STATUS_SIZE_MISMATCH;
      else if (snap.fields[8] != ~snap.payload_crc) status = STATUS_PAYLOAD_CRC_BAD;
      else if (snap.span_bad)                      status = STATUS_SPAN_BAD;
      else if (snap.words_covered != wc)           status = STATUS_WORDS_UNCOVERED;
      else                                         status = STATUS_OK;
   end

endmodule

[src/volume_section_stream_checker.sv]
// ----------------------------------------------------------------------------
// Section stream checker
// Validates a section file streamed one byte per transfer and reports one
// status with the header's record and word counts after the final byte.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle; input stalls only while a verdict waits in
// the snapshot stage behind a result that the sink has not yet taken.
// The snapshot of the final byte is registered, then its verdict waits for the sink;
// the scan step (one unrolled CRC byte) and the verdict each own one stage.
// Reset is synchronous and clears the scanner, both pipeline stages and the
// magic and version registers; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "volume_section_stream_checker_assert.svh"

module volume_section_stream_checker import vssc_pkg::*; #(
   parameter int HEADER_SIZE = 48,
   parameter int RECORD_SIZE = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] stream_byte
   input  logic        req_tlast,    // final_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,    // [2:0] status, [34:3] records_found,
                                     // [66:35] words_found, [71:67] zero
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   logic [31:0] expected_magic_ff;
   logic [15:0] expected_version_ff;

   logic        take;
   snap_type    snap_in, snap_ff;
   logic        snap_valid_ff;
   logic        out_free, snap_free;

   status_type  status_in, rsp_status_ff;
   logic [31:0] rec_ff, words_ff;
   logic        rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_magic_ff   <= '0;
         expected_version_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAGIC:   expected_magic_ff   <= csr_wdata;
            CSR_VERSION: expected_version_ff <= csr_wdata[15:0];
            default:     ;
         endcase
      end
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign snap_free  = !snap_valid_ff || out_free;
   assign req_tready = snap_free;
   assign take       = req_tvalid && req_tready;

   vssc_scan #(
      .HEADER_SIZE(HEADER_SIZE),
      .RECORD_SIZE(RECORD_SIZE)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .byte_in (req_tdata),
      .last_in (req_tlast),
      .snap    (snap_in)
   );

   // Only the final byte of a file fills the snapshot stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
      end else if (take && req_tlast) begin
         snap_valid_ff <= 1'b1;
      end else if (out_free) begin
         snap_valid_ff <= 1'b0;
      end
      if (take && req_tlast) begin
         snap_ff <= snap_in;
      end
   end

   vssc_judge #(
      .HEADER_SIZE(HEADER_SIZE),
      .RECORD_SIZE(RECORD_SIZE)
   ) u_judge (
      .snap             (snap_ff),
      .expected_magic   (expected_magic_ff),
      .expected_version (expected_version_ff),
      .status           (status_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= snap_valid_ff;
      end
      if (out_free && snap_valid_ff) begin
         rsp_status_ff <= status_in;
         rec_ff        <= snap_ff.fields[3];
         words_ff      <= snap_ff.fields[4];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, words_ff, rec_ff, rsp_status_ff};

   `VSSC_ASSERT_RESET(a_reset_empties, !rsp_tvalid && !snap_valid_ff, "pipeline not empty after reset")
   `VSSC_ASSERT_IMPLY(a_stall_blocks, snap_valid_ff && rsp_tvalid && !rsp_tready, !req_tready, "byte taken while the verdict stage is blocked")
   `VSSC_ASSERT_IMPLY(a_ok_has_counts, rsp_tvalid && rsp_status_ff == STATUS_OK, rec_ff != '0 && words_ff != '0, "good status with an empty record or word count")

endmodule

[dv/volume_section_stream_checker_test.sv]
// ----------------------------------------------------------------------------
// Section stream checker testbench
// Streams section files one byte per transfer, some well formed and some with
// a single defect, predicts the verdict of each file in a scoreboard, and
// compares every returned status and count field with the prediction.
// ----------------------------------------------------------------------------

class section_verdict_board;

   localparam int HDR_BYTES = 48;
   localparam int REC_BYTES = 8;

   typedef struct {
      vssc_pkg::status_type status;
      logic [31:0]          records;
      logic [31:0]          words;
   } verdict_type;

   verdict_type pending_verdicts[$];
   logic [31:0] magic_reg;
   logic [15:0] version_reg;

   // Scanner state for the file in flight.
   logic [31:0] pos;
   logic [31:0] hdr_crc;
   logic [31:0] pay_crc;
   logic [31:0] hdr_word[9];
   logic [63:0] shifter;
   logic [31:0] word_cursor;
   bit          hdr_bad;
   bit          span_bad;

   int mismatches;
   int files;
   int bytes_in;
   int status_seen[6];

   function new();
      magic_reg   = '0;
      version_reg = '0;
      restart();
   endfunction

   // Reflected CRC-32, one data bit at a time.
   static function logic [31:0] crc_step(logic [31:0] crc, logic [7:0] b);
      for (int k = 0; k < 8; k++) begin
         if (crc[0] ^ b[k]) begin
            crc = (crc >> 1) ^ vssc_pkg::CRC_POLY;
         end else begin
            crc = crc >> 1;
         end
      end
      return crc;
   endfunction

   function void restart();
      pos         = '0;
      hdr_crc     = '1;
      pay_crc     = '1;
      shifter     = '0;
      word_cursor = '0;
      hdr_bad     = 1'b0;
      span_bad    = 1'b0;
      foreach (hdr_word[i]) hdr_word[i] = '0;
   endfunction

   function void write_register(logic idx, logic [31:0] value);
      if (idx == vssc_pkg::CSR_MAGIC) begin
         magic_reg = value;
      end else begin
         version_reg = value[15:0];
      end
   endfunction

   function int pending();
      return pending_verdicts.size();
   endfunction

   function vssc_pkg::status_type judge();
      logic [31:0] rc;
      logic [31:0] wc;
      rc = hdr_word[3];
      wc = hdr_word[4];
      if (pos < HDR_BYTES || hdr_bad || hdr_word[0] != magic_reg ||
          hdr_word[1][15:0] != version_reg || hdr_word[1][31:16] != HDR_BYTES ||
          hdr_word[5][15:0] != REC_BYTES || hdr_word[5][31:16] != vssc_pkg::WORD_BYTES)
         return vssc_pkg::STATUS_HEADER_BAD;
      if (hdr_word[2] != pos || rc == 0 || wc == 0 ||
          rc > 32'hFFFF_FFFF / REC_BYTES || wc > 32'h7FFF_FFFF ||
          hdr_word[6] != rc * REC_BYTES || hdr_word[7] != wc * 32'd2 ||
          {1'b0, hdr_word[6]} + {1'b0, hdr_word[7]} != {1'b0, pos} - 33'(HDR_BYTES))
         return vssc_pkg::STATUS_SIZE_MISMATCH;
      if (hdr_word[8] != ~pay_crc) return vssc_pkg::STATUS_PAYLOAD_CRC_BAD;
      if (span_bad) return vssc_pkg::STATUS_SPAN_BAD;
      if (word_cursor != wc) return vssc_pkg::STATUS_WORDS_UNCOVERED;
      return vssc_pkg::STATUS_OK;
   endfunction

   // Notes one accepted byte; the final byte of a file queues its verdict.
   function void take_byte(logic [7:0] b, bit last);
      logic [31:0] word;
      logic [31:0] off;
      logic [3:0]  slot;
      verdict_type v;
      bytes_in++;
      // A saturated byte count freezes the scan; the verdict still comes.
      if (pos != 32'hFFFF_FFFF) begin
         shifter = {b, shifter[63:8]};
         word    = shifter[63:32];
         if (pos < vssc_pkg::HDR_CRC_LEN) hdr_crc = crc_step(hdr_crc, b);
         if (pos < vssc_pkg::HDR_FIXED_LEN && pos[1:0] == 2'd3) begin
            slot = pos[5:2];
            if (slot < vssc_pkg::HDR_WORDS) begin
               hdr_word[slot] = word;
            end else if (slot == vssc_pkg::SLOT_RESERVED0 ||
                         slot == vssc_pkg::SLOT_RESERVED1) begin
               hdr_bad |= (word != 0);
            end else begin
               hdr_bad |= (word != ~hdr_crc);
            end
         end
         if (pos >= HDR_BYTES) begin
            off     = pos - HDR_BYTES;
            pay_crc = crc_step(pay_crc, b);
            // The span is read from the first eight bytes of each record.
            if (off / REC_BYTES < hdr_word[3] && off % REC_BYTES == 7 &&
                !span_bad) begin
               if (word == 0 || shifter[31:0] != word_cursor ||
                   word > hdr_word[4] - word_cursor) begin
                  span_bad = 1'b1;
               end else begin
                  word_cursor += word;
               end
            end
         end
         pos++;
      end
      if (last) begin
         v.status  = judge();
         v.records = hdr_word[3];
         v.words   = hdr_word[4];
         pending_verdicts.push_back(v);
         status_seen[v.status]++;
         files++;
         restart();
      end
   endfunction

   function void check_verdict(logic [71:0] d);
      verdict_type want;
      if (pending_verdicts.size() == 0) begin
         mismatches++;
         $display("%0t: unexpected result: expected none, actual status %0d records %0d words %0d",
                  $time, d[2:0], d[34:3], d[66:35]);
         return;
      end
      want = pending_verdicts.pop_front();
      if (d[2:0] != want.status) begin
         mismatches++;
         $display("%0t: status mismatch: expected %0d, actual %0d",
                  $time, want.status, d[2:0]);
      end
      if (d[34:3] != want.records) begin
         mismatches++;
         $display("%0t: records_found mismatch: expected %0d, actual %0d",
                  $time, want.records, d[34:3]);
      end
      if (d[66:35] != want.words) begin
         mismatches++;
         $display("%0t: words_found mismatch: expected %0d, actual %0d",
                  $time, want.words, d[66:35]);
      end
   endfunction

endclass

module volume_section_stream_checker_test;
   import vssc_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int BYTE_TARGET = 1700;
   localparam int HDR_BYTES   = 48;
   localparam int REC_BYTES   = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;    // [7:0] stream_byte
   logic        req_tlast = 1'b0;  // final_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;         // [2:0] status, [34:3] records_found,
                                   // [66:35] words_found, [71:67] zero
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [31:0] csr_wdata = '0;

   section_verdict_board board;
   logic [7:0]           image[$];
   int                   quiet_cycles = 0;
   int                   settings = 1;

   volume_section_stream_checker #(
      .HEADER_SIZE(HDR_BYTES),
      .RECORD_SIZE(REC_BYTES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void put_word(int at, logic [31:0] value);
      for (int k = 0; k < 4; k++) image[at + k] = value[8*k +: 8];
   endfunction

   function automatic logic [31:0] get_word(int at);
      return {image[at + 3], image[at + 2], image[at + 1], image[at]};
   endfunction

   // Refreshes the payload CRC field (optionally) and then the header CRC.
   function automatic void seal_section(bit with_payload);
      logic [31:0] c;
      if (with_payload) begin
         c = '1;
         for (int i = HDR_BYTES; i < image.size(); i++) begin
            c = board.crc_step(c, image[i]);
         end
         put_word(32, ~c);
      end
      c = '1;
      for (int i = 0; i < HDR_CRC_LEN; i++) c = board.crc_step(c, image[i]);
      put_word(44, ~c);
   endfunction

   // A consistent file whose spans cover `covered` words; `spare` words beyond
   // them are declared in the header and carried in the word stream.
   function automatic void build_section(int rc, int covered, int spare);
      int total;
      int left;
      int cnt;
      int first;
      total = covered + spare;
      left  = covered - rc;
      first = 0;
      image.delete();
      repeat (HDR_BYTES) image.push_back(8'h00);
      put_word(0, board.magic_reg);
      put_word(4, {16'(HDR_BYTES), board.version_reg});
      put_word(8, HDR_BYTES + rc * 8 + total * 2);
      put_word(12, rc);
      put_word(16, total);
      put_word(20, {WORD_BYTES, 16'(REC_BYTES)});
      put_word(24, rc * 8);
      put_word(28, total * 2);
      for (int r = 0; r < rc; r++) begin
         cnt = 1 + ((r == rc - 1) ? left : $urandom_range(0, left));
         left -= cnt - 1;
         repeat (8) image.push_back(8'h00);
         put_word(HDR_BYTES + 8 * r, first);
         put_word(HDR_BYTES + 8 * r + 4, cnt);
         first += cnt;
      end
      repeat (2 * total) image.push_back(8'($urandom));
      seal_section(1'b1);
   endfunction

   task automatic send_section();
      int gap;
      bit burst;
      burst = ($urandom_range(0, 3) == 0);
      foreach (image[i]) begin
         gap = burst ? 0 : $urandom_range(0, 17);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= image[i];
         req_tlast  <= (i == image.size() - 1);
         do @(posedge clock); while (!req_tready);
         board.take_byte(image[i], i == image.size() - 1);
      end
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_registers(logic [31:0] magic, logic [15:0] version);
      logic [31:0] ver_word;
      ver_word = {16'($urandom), version};
      csr_we    <= 1'b1;
      csr_index <= CSR_MAGIC;
      csr_wdata <= magic;
      board.write_register(CSR_MAGIC, magic);
      @(posedge clock);
      csr_index <= CSR_VERSION;
      csr_wdata <= ver_word;
      board.write_register(CSR_VERSION, ver_word);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_section();
      int kind;
      int rc;
      int at;
      int sel;
      kind = $urandom_range(0, 99);
      rc   = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
      build_section(rc, rc + $urandom_range(0, 8),
                    (kind >= 58 && kind < 64) ? $urandom_range(1, 3) : 0);
      if (kind >= 40 && kind < 50) begin
         at = $urandom_range(0, image.size() - 1);
         image[at] ^= 8'(1 << $urandom_range(0, 7));
      end else if (kind >= 50 && kind < 58) begin
         at  = HDR_BYTES + 8 * $urandom_range(0, rc - 1);
         sel = $urandom_range(0, 2);
         if (sel == 0) begin
            put_word(at + 4, 0);
         end else if (sel == 1) begin
            put_word(at, get_word(at) + $urandom_range(1, 3));
         end else begin
            put_word(at + 4, get_word(at + 4) + $urandom_range(1, 4));
         end
         seal_section(1'b1);
      end else if (kind >= 64 && kind < 70) begin
         repeat ($urandom_range(1, image.size() - 1)) void'(image.pop_back());
      end else if (kind >= 70 && kind < 74) begin
         repeat ($urandom_range(1, 6)) image.push_back(8'($urandom));
      end else if (kind >= 74 && kind < 80) begin
         // One byte of a fixed header field goes wrong under a valid header CRC.
         case ($urandom_range(0, 5))
            0: at = $urandom_range(0, 3);
            1: at = $urandom_range(4, 5);
            2: at = $urandom_range(6, 7);
            3: at = $urandom_range(20, 21);
            4: at = $urandom_range(22, 23);
            default: at = $urandom_range(36, 43);
         endcase
         image[at] ^= 8'($urandom_range(1, 255));
         seal_section(1'b1);
      end else if (kind >= 80 && kind < 86) begin
         case ($urandom_range(0, 4))
            0: at = 8;
            1: at = 12;
            2: at = 16;
            3: at = 24;
            default: at = 28;
         endcase
         image[at + $urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
         seal_section(1'b1);
      end else if (kind >= 86 && kind < 92) begin
         if ($urandom_range(0, 1) == 0) begin
            at = $urandom_range(HDR_BYTES, image.size() - 1);
            image[at] ^= 8'($urandom_range(1, 255));
            seal_section(1'b0);
         end else begin
            image[$urandom_range(44, 47)] ^= 8'($urandom_range(1, 255));
         end
      end else if (kind >= 92) begin
         image.delete();
         repeat ($urandom_range(1, 64)) image.push_back(8'($urandom));
      end
      send_section();
   endtask

   // The result side stalls a random number of cycles before each transfer,
   // with runs of back-to-back readiness.
   initial begin : result_sink
      int gap;
      bit burst;
      burst = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 7) == 0) burst = ~burst;
         gap = burst ? 0 : $urandom_range(0, 17);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         board.check_verdict(rsp_tdata);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
         $display("volume_section_stream_checker_test: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int short_lens[3];
      logic [31:0] magic;
      logic [15:0] version;
      short_lens = '{1, 20, 47};
      board = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Files cut short inside the header.
      foreach (short_lens[k]) begin
         image.delete();
         repeat (short_lens[k]) image.push_back(8'($urandom));
         send_section();
      end
      // Smallest well-formed file.
      build_section(1, 1, 0);
      send_section();
      // Zero record count, zero word count.
      build_section(2, 5, 0);
      put_word(12, 0);
      seal_section(1'b1);
      send_section();
      build_section(1, 2, 0);
      put_word(16, 0);
      seal_section(1'b1);
      send_section();
      // Counts whose byte totals wrap around 32 bits.
      build_section(1, 1, 0);
      put_word(12, 32'h2000_0001);
      seal_section(1'b1);
      send_section();
      build_section(1, 1, 0);
      put_word(16, 32'h8000_0001);
      seal_section(1'b1);
      send_section();
      // Payload corrupted under a valid header.
      build_section(2, 4, 0);
      image[HDR_BYTES + 17] ^= 8'h80;
      seal_section(1'b0);
      send_section();
      // Empty span, words left uncovered, nonzero reserved word.
      build_section(3, 6, 0);
      put_word(HDR_BYTES + 12, 0);
      seal_section(1'b1);
      send_section();
      build_section(2, 6, 2);
      send_section();
      build_section(1, 3, 0);
      put_word(40, 32'h0000_0100);
      seal_section(1'b1);
      send_section();

      settle();
      program_registers(32'hFFFF_FFFF, 16'hFFFF);
      settings++;
      build_section(3, 8, 0);
      send_section();

      while (board.bytes_in < BYTE_TARGET) begin
         settle();
         case ($urandom_range(0, 3))
            0: magic = '0;
            1: magic = '1;
            default: magic = $urandom;
         endcase
         case ($urandom_range(0, 3))
            0: version = '0;
            1: version = '1;
            default: version = 16'($urandom);
         endcase
         program_registers(magic, version);
         settings++;
         for (int n = 0; n < 8 && board.bytes_in < BYTE_TARGET; n++) random_section();
      end
      settle();

      $display("Checked %0d section files in %0d byte transfers under %0d register settings.",
               board.files, board.bytes_in, settings);
      $display("Verdicts: ok %0d, header %0d, sizes %0d, payload crc %0d, span %0d, uncovered %0d.",
               board.status_seen[STATUS_OK], board.status_seen[STATUS_HEADER_BAD],
               board.status_seen[STATUS_SIZE_MISMATCH],
               board.status_seen[STATUS_PAYLOAD_CRC_BAD],
               board.status_seen[STATUS_SPAN_BAD], board.status_seen[STATUS_WORDS_UNCOVERED]);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("volume_section_stream_checker_test: PASS");
      end else begin
         $display("volume_section_stream_checker_test: FAIL");
      end
      $finish;
   end

endmodule
